// ===== rtl/assert_macros.svh =====
// Assertion macros, included by multi_key_record_sorter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MKRS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MKRS_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define MKRS_ASSERT(lbl, clk, rst_n, prop, msg)
`define MKRS_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

// ===== rtl/mkrs_pkg.sv =====
// ----------------------------------------------------------------------------
// mkrs_pkg
// Types and constants of the multi-key record sorter.
// ----------------------------------------------------------------------------
`default_nettype none
package mkrs_pkg;
  localparam int RECORDS = 1024;
  localparam int IDX_W   = $clog2(RECORDS);
  localparam int CNT_W   = IDX_W + 1;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  localparam logic [1:0] KEY_NAME       = 2'd0;
  localparam logic [1:0] KEY_SURNAME    = 2'd1;
  localparam logic [1:0] KEY_PATRONYMIC = 2'd2;
  localparam logic [1:0] KEY_PHONE      = 2'd3;

  localparam logic       ACT_LOAD = 1'b0;
  localparam logic [7:0] KEY_ORDER_RESET = 8'd228;

  typedef struct packed {
    logic [63:0] high;
    logic [63:0] mid;
    logic [31:0] low;
  } text_t;

  typedef struct packed {
    text_t       name;
    text_t       surname;
    text_t       patronymic;
    logic [63:0] phone;
  } rec_t;

  localparam int REC_W = $bits(rec_t);
endpackage
`default_nettype wire

// ===== rtl/mkrs_if.sv =====
// ----------------------------------------------------------------------------
// mkrs_if
// Channel interfaces: input items, result items and the key order write.
// ----------------------------------------------------------------------------
`default_nettype none
interface mkrs_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [63:0] name_word_high;
  logic [63:0] name_word_mid;
  logic [31:0] name_word_low;
  logic [63:0] surname_word_high;
  logic [63:0] surname_word_mid;
  logic [31:0] surname_word_low;
  logic [63:0] patronymic_word_high;
  logic [63:0] patronymic_word_mid;
  logic [31:0] patronymic_word_low;
  logic [63:0] phone_number;
  modport source (output valid, action, name_word_high, name_word_mid, name_word_low,
                  surname_word_high, surname_word_mid, surname_word_low,
                  patronymic_word_high, patronymic_word_mid, patronymic_word_low,
                  phone_number, input ready);
  modport sink (input valid, action, name_word_high, name_word_mid, name_word_low,
                surname_word_high, surname_word_mid, surname_word_low,
                patronymic_word_high, patronymic_word_mid, patronymic_word_low,
                phone_number, output ready);
endinterface

interface mkrs_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_name_high;
  logic [63:0] out_name_mid;
  logic [31:0] out_name_low;
  logic [63:0] out_surname_high;
  logic [63:0] out_surname_mid;
  logic [31:0] out_surname_low;
  logic [63:0] out_patronymic_high;
  logic [63:0] out_patronymic_mid;
  logic [31:0] out_patronymic_low;
  logic [63:0] out_phone;
  logic        final_record;
  logic [1:0]  status;
  modport source (output valid, out_name_high, out_name_mid, out_name_low,
                  out_surname_high, out_surname_mid, out_surname_low,
                  out_patronymic_high, out_patronymic_mid, out_patronymic_low,
                  out_phone, final_record, status, input ready);
  modport sink (input valid, out_name_high, out_name_mid, out_name_low,
                out_surname_high, out_surname_mid, out_surname_low,
                out_patronymic_high, out_patronymic_mid, out_patronymic_low,
                out_phone, final_record, status, output ready);
endinterface

interface mkrs_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/mkrs_ram.sv =====
// ----------------------------------------------------------------------------
// mkrs_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module mkrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/mkrs_cmp.sv =====
// ----------------------------------------------------------------------------
// mkrs_cmp
// Multi-key record compare: a_gt_b when record a sorts after record b.
// ----------------------------------------------------------------------------
`default_nettype none
module mkrs_cmp import mkrs_pkg::*; (
  input  wire rec_t       a,
  input  wire rec_t       b,
  input  wire logic [7:0] key_order,
  output logic            a_gt_b
);
  logic [3:0] gt;
  logic [3:0] lt;

  assign gt = {a.phone > b.phone, a.patronymic > b.patronymic,
               a.surname > b.surname, a.name > b.name};
  assign lt = {a.phone < b.phone, a.patronymic < b.patronymic,
               a.surname < b.surname, a.name < b.name};

  // First slot that differs decides.
  always_comb begin
    logic       decided;
    logic [1:0] code;
    decided = 1'b0;
    a_gt_b  = 1'b0;
    for (int s = 0; s < 4; s++) begin
      code = key_order[2*s +: 2];
      if (!decided && (gt[code] || lt[code])) begin
        a_gt_b  = gt[code];
        decided = 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/multi_key_record_sorter.sv =====
// ----------------------------------------------------------------------------
// multi_key_record_sorter
// Record store with a stable multi-key insertion sort on first read.
// ----------------------------------------------------------------------------
// A load transaction writes the record to the record RAM and its own index
// to the index RAM. A read transaction runs an index RAM read, a record RAM
// read and the output. The first read after a set of two or more records was
// loaded first runs an insertion sort over the index RAM. Each record from
// the second on is fetched (index read, record read, load), passes each slot
// it shifts past (index read, record read, compare and shift), ends with a
// closing check (a single state when it reaches slot 0, or index read,
// record read and compare when a compare stops it) and is then inserted.
// The whole sort runs before the read itself. Records compare key by key
// in the priority of key_order; ties keep load order. No input transaction
// is taken while a sort runs. The key order register is always ready and
// is meant to be written while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module multi_key_record_sorter import mkrs_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  mkrs_in_if.sink     in_chan,
  mkrs_out_if.source  out_chan,
  mkrs_cfg_if.sink    cfg_chan
);
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SI_RD  = 4'd1;
  localparam logic [3:0] S_SI_REC = 4'd2;
  localparam logic [3:0] S_SI_LD  = 4'd3;
  localparam logic [3:0] S_SJ_CHK = 4'd4;
  localparam logic [3:0] S_SJ_IDX = 4'd5;
  localparam logic [3:0] S_SJ_CMP = 4'd6;
  localparam logic [3:0] S_SINS   = 4'd7;
  localparam logic [3:0] S_RD     = 4'd8;
  localparam logic [3:0] S_RD_IDX = 4'd9;
  localparam logic [3:0] S_RD_REC = 4'd10;

  logic [3:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] pos_r, pos_nxt;
  logic             sorted_r, sorted_nxt;
  logic [7:0]       key_order_r;
  logic [CNT_W-1:0] i_r, i_nxt;
  logic [CNT_W-1:0] j_r, j_nxt;
  logic [IDX_W-1:0] cur_r, cur_nxt;
  logic [IDX_W-1:0] prev_r, prev_nxt;
  rec_t             cur_rec_r, cur_rec_nxt;

  logic             out_valid_r, out_valid_nxt;
  rec_t             out_rec_r, out_rec_nxt;
  logic             out_final_r, out_final_nxt;
  logic [1:0]       out_status_r, out_status_nxt;

  logic             rec_we, idx_we;
  logic [IDX_W-1:0] rec_waddr, rec_raddr, idx_waddr, idx_raddr;
  logic [IDX_W-1:0] idx_wdata, idx_rdata;
  rec_t             rec_wdata, rec_rdata;
  logic             prev_gt_cur;

  logic             in_acc;
  logic [CNT_W-1:0] load_count;
  logic [CNT_W-1:0] j_dec;

  // Record RAM and index RAM; no read whose data is used ever overlaps a write
  // to the same entry in one cycle, so neither needs forwarding.
  mkrs_ram #(.WIDTH(REC_W), .DEPTH(RECORDS)) u_rec_ram (
    .clk(clk), .we(rec_we), .waddr(rec_waddr), .wdata(rec_wdata),
    .raddr(rec_raddr), .rdata(rec_rdata)
  );

  mkrs_ram #(.WIDTH(IDX_W), .DEPTH(RECORDS)) u_idx_ram (
    .clk(clk), .we(idx_we), .waddr(idx_waddr), .wdata(idx_wdata),
    .raddr(idx_raddr), .rdata(idx_rdata)
  );

  // Record fetched at j-1 against the record being inserted.
  mkrs_cmp u_cmp (
    .a(rec_rdata), .b(cur_rec_r), .key_order(key_order_r), .a_gt_b(prev_gt_cur)
  );

  assign in_chan.ready  = (state_r == S_IDLE) && (!out_valid_r || out_chan.ready);
  assign in_acc         = in_chan.valid && in_chan.ready;
  assign cfg_chan.ready = 1'b1;
  // A load after a sorted set starts a new set.
  assign load_count     = sorted_r ? '0 : count_r;
  assign j_dec          = j_r - 1'b1;

  assign rec_wdata.name       = '{in_chan.name_word_high, in_chan.name_word_mid,
                                  in_chan.name_word_low};
  assign rec_wdata.surname    = '{in_chan.surname_word_high, in_chan.surname_word_mid,
                                  in_chan.surname_word_low};
  assign rec_wdata.patronymic = '{in_chan.patronymic_word_high,
                                  in_chan.patronymic_word_mid,
                                  in_chan.patronymic_word_low};
  assign rec_wdata.phone      = in_chan.phone_number;
  assign rec_waddr            = load_count[IDX_W-1:0];

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    pos_nxt        = pos_r;
    sorted_nxt     = sorted_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    cur_rec_nxt    = cur_rec_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_rec_nxt    = out_rec_r;
    out_final_nxt  = out_final_r;
    out_status_nxt = out_status_r;
    rec_we         = 1'b0;
    idx_we         = 1'b0;
    idx_waddr      = load_count[IDX_W-1:0];
    idx_wdata      = load_count[IDX_W-1:0];
    rec_raddr      = idx_rdata;
    idx_raddr      = i_r[IDX_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_chan.action == ACT_LOAD) begin
            // Loads answer with an all-zero record.
            out_valid_nxt = 1'b1;
            out_rec_nxt   = '0;
            out_final_nxt = 1'b0;
            sorted_nxt    = 1'b0;
            pos_nxt       = sorted_r ? '0 : pos_r;
            if (load_count == CNT_W'(RECORDS)) begin
              count_nxt      = load_count;
              out_status_nxt = STAT_FULL;
            end else begin
              rec_we         = 1'b1;
              idx_we         = 1'b1;
              count_nxt      = load_count + 1'b1;
              out_status_nxt = STAT_OK;
            end
          end else if (sorted_r || count_r < CNT_W'(2)) begin
            sorted_nxt = 1'b1;
            pos_nxt    = sorted_r ? pos_r : '0;
            state_nxt  = S_RD;
          end else begin
            i_nxt     = CNT_W'(1);
            state_nxt = S_SI_RD;
          end
        end
      end
      S_SI_RD: begin
        // Index RAM read of slot i is under way.
        state_nxt = S_SI_REC;
      end
      S_SI_REC: begin
        cur_nxt   = idx_rdata;
        state_nxt = S_SI_LD;
      end
      S_SI_LD: begin
        cur_rec_nxt = rec_rdata;
        j_nxt       = i_r;
        state_nxt   = S_SJ_CHK;
      end
      S_SJ_CHK: begin
        idx_raddr = j_dec[IDX_W-1:0];
        state_nxt = (j_r == '0) ? S_SINS : S_SJ_IDX;
      end
      S_SJ_IDX: begin
        prev_nxt  = idx_rdata;
        state_nxt = S_SJ_CMP;
      end
      S_SJ_CMP: begin
        // Shift the larger record up one slot, or stop here.
        if (prev_gt_cur) begin
          idx_we    = 1'b1;
          idx_waddr = j_r[IDX_W-1:0];
          idx_wdata = prev_r;
          j_nxt     = j_dec;
          state_nxt = S_SJ_CHK;
        end else begin
          state_nxt = S_SINS;
        end
      end
      S_SINS: begin
        idx_we    = 1'b1;
        idx_waddr = j_r[IDX_W-1:0];
        idx_wdata = cur_r;
        i_nxt     = i_r + 1'b1;
        idx_raddr = i_nxt[IDX_W-1:0];
        if (i_nxt < count_r) begin
          state_nxt = S_SI_RD;
        end else begin
          sorted_nxt = 1'b1;
          pos_nxt    = '0;
          state_nxt  = S_RD;
        end
      end
      S_RD: begin
        idx_raddr = pos_r[IDX_W-1:0];
        if (pos_r >= count_r) begin
          out_valid_nxt  = 1'b1;
          out_rec_nxt    = '0;
          out_final_nxt  = 1'b0;
          out_status_nxt = STAT_EMPTY;
          state_nxt      = S_IDLE;
        end else begin
          state_nxt = S_RD_IDX;
        end
      end
      S_RD_IDX: begin
        state_nxt = S_RD_REC;
      end
      S_RD_REC: begin
        out_valid_nxt  = 1'b1;
        out_rec_nxt    = rec_rdata;
        pos_nxt        = pos_r + 1'b1;
        out_final_nxt  = (pos_nxt == count_r);
        out_status_nxt = STAT_OK;
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pos_r       <= '0;
      sorted_r    <= 1'b0;
      key_order_r <= KEY_ORDER_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pos_r       <= pos_nxt;
      sorted_r    <= sorted_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_chan.valid) begin
        key_order_r <= cfg_chan.data;
      end
    end
  end

  // Payload registers: no reset.
  always_ff @(posedge clk) begin
    i_r          <= i_nxt;
    j_r          <= j_nxt;
    cur_r        <= cur_nxt;
    prev_r       <= prev_nxt;
    cur_rec_r    <= cur_rec_nxt;
    out_rec_r    <= out_rec_nxt;
    out_final_r  <= out_final_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_chan.valid               = out_valid_r;
  assign out_chan.out_name_high       = out_rec_r.name.high;
  assign out_chan.out_name_mid        = out_rec_r.name.mid;
  assign out_chan.out_name_low        = out_rec_r.name.low;
  assign out_chan.out_surname_high    = out_rec_r.surname.high;
  assign out_chan.out_surname_mid     = out_rec_r.surname.mid;
  assign out_chan.out_surname_low     = out_rec_r.surname.low;
  assign out_chan.out_patronymic_high = out_rec_r.patronymic.high;
  assign out_chan.out_patronymic_mid  = out_rec_r.patronymic.mid;
  assign out_chan.out_patronymic_low  = out_rec_r.patronymic.low;
  assign out_chan.out_phone           = out_rec_r.phone;
  assign out_chan.final_record        = out_final_r;
  assign out_chan.status              = out_status_r;

  `MKRS_ASSERT(a_count_bound, clk, rst_n, (count_r <= CNT_W'(RECORDS)), "count overflow")
  `MKRS_ASSERT(a_pos_bound, clk, rst_n, (pos_r <= count_r), "read position past count")
  `MKRS_ASSERT(a_sort_i, clk, rst_n, (state_r == S_SINS |-> i_r < count_r), "sort index out of set")
  `MKRS_ASSERT_NEXT(a_full_drop, clk, rst_n,
    in_acc && in_chan.action == ACT_LOAD && !sorted_r && count_r == CNT_W'(RECORDS),
    out_valid_r && out_status_r == STAT_FULL && count_r == CNT_W'(RECORDS),
    "full store load not dropped")
endmodule
`default_nettype wire
